/* rtl/core/arcfd_pkg.sv */
// ----------------------------------------------------------------------------
// arcfd_pkg
// Shared types and constants of the alignment record CIGAR and flag decoder.
// ----------------------------------------------------------------------------
package arcfd_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INSERT_MAPQ = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLIP_LEN    = 4'd1;

  localparam logic [7:0]  MIN_INSERT_MAPQ_RST = 8'd40;
  localparam logic [27:0] MIN_CLIP_LEN_RST    = 28'd1;

  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  localparam int FLAG_PAIRED        = 0;
  localparam int FLAG_MATE_UNMAPPED = 3;
  localparam int FLAG_REVERSE       = 4;
  localparam int FLAG_READ1         = 6;
  localparam int FLAG_READ2         = 7;
  localparam int FLAG_SECONDARY     = 8;
  localparam int FLAG_QC_FAIL       = 9;
  localparam int FLAG_DUPLICATE     = 10;
  localparam int FLAG_SUPPLEMENTARY = 11;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_READ1 = 2'd1;
  localparam logic [1:0] ROLE_READ2 = 2'd2;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [27:0] len;
    logic        is_clip;
    logic        is_del;
    logic        is_ref;
    logic        first;
    logic        last;
    logic [30:0] begin_pos;
    logic [15:0] flags;
    logic [7:0]  mapq;
  } op_item_t;

  typedef struct packed {
    logic [30:0] ref_len;
    logic [27:0] left_clip;
    logic [27:0] right_clip;
    logic        del_seen;
    logic [27:0] del_len;
    logic [30:0] begin_pos;
    logic [15:0] flags;
    logic [7:0]  mapq;
  } read_sum_t;

  typedef struct packed {
    logic [31:0] end_pos;
    logic [30:0] ref_length;
    logic [27:0] left_clip;
    logic [27:0] right_clip;
    logic        has_deletion;
    logic [27:0] deletion_len;
    logic [1:0]  mate_role;
    logic [31:0] five_prime_pos;
    logic [31:0] three_prime_pos;
    logic        passes_insert;
    logic        passes_standard;
    logic        clipped_at_min;
  } result_t;

endpackage

/* rtl/core/arcfd_front.sv */
// ----------------------------------------------------------------------------
// arcfd_front
// Input side: takes one CIGAR op beat, splits the word and classifies the op.
// ----------------------------------------------------------------------------
module arcfd_front import arcfd_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] cigar_word,
  input  logic        has_op,
  input  logic        first_op,
  input  logic        last_op,
  input  logic [30:0] begin_pos,
  input  logic [15:0] flag_word,
  input  logic [7:0]  map_quality,
  input  logic        q_full,
  output logic        q_push,
  output op_item_t    q_item
);

  logic [3:0] code;

  assign code     = cigar_word[3:0];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item           = '0;
    q_item.len       = cigar_word[31:4];
    q_item.is_clip   = has_op && (code inside {OP_S, OP_H});
    q_item.is_del    = has_op && (code == OP_D);
    q_item.is_ref    = has_op && (code inside {OP_M, OP_D, OP_N, OP_EQ, OP_X});
    q_item.first     = first_op;
    q_item.last      = last_op;
    q_item.begin_pos = begin_pos;
    q_item.flags     = flag_word;
    q_item.mapq      = map_quality;
  end

endmodule

/* rtl/core/arcfd_queue.sv */
// ----------------------------------------------------------------------------
// arcfd_queue
// Short queue of classified ops between the input side and the accumulator.
// ----------------------------------------------------------------------------
module arcfd_queue import arcfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  op_item_t wr_item,
  output logic     full,
  input  logic     pop,
  output logic     rd_valid,
  output op_item_t rd_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_item_t           mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/core/arcfd_back.sv */
// ----------------------------------------------------------------------------
// arcfd_back
// Accumulator and result stages: sums reference op lengths per read, then computes
// the end position and filter verdicts into the output register.
// ----------------------------------------------------------------------------
module arcfd_back import arcfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  op_item_t    q_item,
  output logic        q_pop,
  input  logic [7:0]  min_insert_mapq,
  input  logic [27:0] min_clip_len,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     res
);

  logic [30:0] acc;
  logic [27:0] left_clip;
  logic        del_seen;
  logic [27:0] del_len;

  logic [30:0] acc_base;
  logic [31:0] acc_sum;
  logic [30:0] acc_next;
  logic [27:0] left_clip_next;
  logic        del_seen_next;
  logic [27:0] del_len_next;
  logic [27:0] right_clip;

  logic        fin_valid;
  read_sum_t   fin;
  logic        s2_load;
  logic        fin_free;

  logic [31:0] sum;
  logic [31:0] sum_m1;
  logic [31:0] end_calc;
  logic        reverse;
  logic        standard;
  result_t     res_next;

  assign s2_load  = !out_valid || out_ready;
  assign fin_free = !fin_valid || s2_load;
  assign q_pop    = q_valid && (!q_item.last || fin_free);

  always_comb begin
    acc_base = q_item.first ? '0 : acc;
    acc_sum  = {1'b0, acc_base} + {4'b0, q_item.len};
    if (!q_item.is_ref) begin
      acc_next = acc_base;
    end else if (acc_sum[31]) begin
      acc_next = MAX31;
    end else begin
      acc_next = acc_sum[30:0];
    end
    left_clip_next = (q_item.first && q_item.is_clip) ? q_item.len :
                     (q_item.first ? '0 : left_clip);
    del_seen_next  = (q_item.first ? 1'b0 : del_seen) | q_item.is_del;
    del_len_next   = q_item.is_del ? q_item.len : (q_item.first ? '0 : del_len);
    right_clip     = (q_item.last && q_item.is_clip) ? q_item.len : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      left_clip <= '0;
      del_seen  <= 1'b0;
      del_len   <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        acc       <= '0;
        left_clip <= '0;
        del_seen  <= 1'b0;
        del_len   <= '0;
      end else begin
        acc       <= acc_next;
        left_clip <= left_clip_next;
        del_seen  <= del_seen_next;
        del_len   <= del_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      fin_valid <= 1'b1;
    end else if (s2_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      fin.ref_len    <= acc_next;
      fin.left_clip  <= left_clip_next;
      fin.right_clip <= right_clip;
      fin.del_seen   <= del_seen_next;
      fin.del_len    <= del_len_next;
      fin.begin_pos  <= q_item.begin_pos;
      fin.flags      <= q_item.flags;
      fin.mapq       <= q_item.mapq;
    end
  end

  always_comb begin
    sum    = {1'b0, fin.begin_pos} + {1'b0, fin.ref_len};
    sum_m1 = sum - 32'd1;
    if (sum == '0) begin
      end_calc = '1;
    end else if (sum_m1[31]) begin
      end_calc = {1'b0, MAX31};
    end else begin
      end_calc = sum_m1;
    end
    reverse  = fin.flags[FLAG_REVERSE];
    standard = !fin.flags[FLAG_MATE_UNMAPPED] && !fin.flags[FLAG_DUPLICATE] &&
               fin.flags[FLAG_PAIRED] && !fin.flags[FLAG_SECONDARY] &&
               !fin.flags[FLAG_SUPPLEMENTARY];

    res_next                 = '0;
    res_next.end_pos         = end_calc;
    res_next.ref_length      = fin.ref_len;
    res_next.left_clip       = fin.left_clip;
    res_next.right_clip      = fin.right_clip;
    res_next.has_deletion    = fin.del_seen;
    res_next.deletion_len    = fin.del_len;
    if (fin.flags[FLAG_READ1] && !fin.flags[FLAG_READ2]) begin
      res_next.mate_role = ROLE_READ1;
    end else if (fin.flags[FLAG_READ2] && !fin.flags[FLAG_READ1]) begin
      res_next.mate_role = ROLE_READ2;
    end else begin
      res_next.mate_role = ROLE_NONE;
    end
    res_next.five_prime_pos  = reverse ? end_calc : {1'b0, fin.begin_pos};
    res_next.three_prime_pos = reverse ? {1'b0, fin.begin_pos} : end_calc;
    res_next.passes_standard = standard;
    res_next.passes_insert   = standard && !fin.flags[FLAG_QC_FAIL] &&
                               (fin.left_clip == '0) && (fin.right_clip == '0) &&
                               !fin.del_seen && (fin.mapq >= min_insert_mapq);
    res_next.clipped_at_min  = (fin.left_clip >= min_clip_len) ||
                               (fin.right_clip >= min_clip_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && fin_valid) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && !s2_load) |=> fin_valid)
    else $error("read summary dropped while output stalled");

  a_last_to_fin: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.last) |=> fin_valid)
    else $error("last op did not produce a read summary");

  a_clear_after_read: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.last) |=> (acc == '0 && left_clip == '0 && !del_seen))
    else $error("accumulators not cleared after read");
`endif

endmodule

/* rtl/core/alignment_record_cigar_flag_decoder.sv */
// ----------------------------------------------------------------------------
// alignment_record_cigar_flag_decoder
// Decodes the CIGAR ops and SAM flags of aligned reads into positions, clip
// and deletion lengths, mate role and filter verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one CIGAR op per beat. Mark the first op
//   with first_op and the last with last_op; begin_pos, flag_word and
//   map_quality are taken from the last beat. A read with no ops is one beat
//   with has_op low and last_op high.
//   Output channel (out_valid/out_ready): one result beat per read.
//   Config channel (cfg_valid/cfg_ready): index 0 min_insert_mapq, index 1
//   min_clip_len; cfg_ready is always high. Write only while the block is idle.
// Throughput: one op per cycle unless the output stalls, set by the accumulator.
// Result path: the last op beat of a read passes the op queue, the read
//   summary stage and the result stage, each registered, to the output.
// Reset: rst clears the op queue, accumulators and output, and loads the
//   register defaults (40 and 1).
// Stall: the output register holds while out_ready is low; the read summary
//   stage and the op queue (QUEUE_DEPTH entries) fill, then in_ready drops.
// ----------------------------------------------------------------------------
module alignment_record_cigar_flag_decoder import arcfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           cigar_word,
  input  logic                  has_op,
  input  logic                  first_op,
  input  logic                  last_op,
  input  logic [30:0]           begin_pos,
  input  logic [15:0]           flag_word,
  input  logic [7:0]            map_quality,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    end_pos,
  output logic [30:0]           ref_length,
  output logic [27:0]           left_clip,
  output logic [27:0]           right_clip,
  output logic                  has_deletion,
  output logic [27:0]           deletion_len,
  output logic [1:0]            mate_role,
  output logic signed [31:0]    five_prime_pos,
  output logic signed [31:0]    three_prime_pos,
  output logic                  passes_insert,
  output logic                  passes_standard,
  output logic                  clipped_at_min,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]  min_insert_mapq;
  logic [27:0] min_clip_len;

  logic        q_full;
  logic        q_push;
  op_item_t    q_wr_item;
  logic        q_valid;
  op_item_t    q_rd_item;
  logic        q_pop;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_insert_mapq <= MIN_INSERT_MAPQ_RST;
      min_clip_len    <= MIN_CLIP_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_INSERT_MAPQ: min_insert_mapq <= cfg_data[7:0];
        REG_MIN_CLIP_LEN:    min_clip_len    <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  arcfd_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cigar_word  (cigar_word),
    .has_op      (has_op),
    .first_op    (first_op),
    .last_op     (last_op),
    .begin_pos   (begin_pos),
    .flag_word   (flag_word),
    .map_quality (map_quality),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_wr_item)
  );

  arcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  arcfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_rd_item),
    .q_pop           (q_pop),
    .min_insert_mapq (min_insert_mapq),
    .min_clip_len    (min_clip_len),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .res             (res)
  );

  assign end_pos         = signed'(res.end_pos);
  assign ref_length      = res.ref_length;
  assign left_clip       = res.left_clip;
  assign right_clip      = res.right_clip;
  assign has_deletion    = res.has_deletion;
  assign deletion_len    = res.deletion_len;
  assign mate_role       = res.mate_role;
  assign five_prime_pos  = signed'(res.five_prime_pos);
  assign three_prime_pos = signed'(res.three_prime_pos);
  assign passes_insert   = res.passes_insert;
  assign passes_standard = res.passes_standard;
  assign clipped_at_min  = res.clipped_at_min;

endmodule

/* dv/alignment_record_cigar_flag_decoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alignment_record_cigar_flag_decoder_checker
// Watches the op, result and register channels of the CIGAR and flag decoder.
// Keeps its own copy of the read accumulators and filter limits, forms the
// expected read summary at every last-op beat and compares each result beat
// field by field, in order, against the oldest pending summary.
// ----------------------------------------------------------------------------
module alignment_record_cigar_flag_decoder_checker import arcfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [31:0]           cigar_word,
  input  logic                  has_op,
  input  logic                  first_op,
  input  logic                  last_op,
  input  logic [30:0]           begin_pos,
  input  logic [15:0]           flag_word,
  input  logic [7:0]            map_quality,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [31:0]    end_pos,
  input  logic [30:0]           ref_length,
  input  logic [27:0]           left_clip,
  input  logic [27:0]           right_clip,
  input  logic                  has_deletion,
  input  logic [27:0]           deletion_len,
  input  logic [1:0]            mate_role,
  input  logic signed [31:0]    five_prime_pos,
  input  logic signed [31:0]    three_prime_pos,
  input  logic                  passes_insert,
  input  logic                  passes_standard,
  input  logic                  clipped_at_min,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    result_count,
  output int                    insert_count
);

  logic [7:0]  insert_mapq_min;
  logic [27:0] clip_len_min;
  logic [30:0] read_ref_len;
  logic [27:0] read_left_clip;
  logic        read_del_seen;
  logic [27:0] read_del_len;
  result_t     expected_reads[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    insert_count = 0;
  end

  task automatic clear_read();
    read_ref_len   = '0;
    read_left_clip = '0;
    read_del_seen  = 1'b0;
    read_del_len   = '0;
  endtask

  task automatic match_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic decode_beat();
    logic [3:0]  code;
    logic [27:0] len;
    logic [27:0] tail_clip;
    logic [31:0] len_sum;
    logic [31:0] pos_sum;
    logic [31:0] end_v;
    logic        rev;
    logic        std_ok;
    result_t     summary;
    code      = cigar_word[3:0];
    len       = cigar_word[31:4];
    tail_clip = '0;
    if (first_op) clear_read();
    if (has_op) begin
      if (code == OP_S || code == OP_H) begin
        if (first_op) read_left_clip = len;
        if (last_op) tail_clip = len;
      end
      if (code == OP_D) begin
        read_del_seen = 1'b1;
        read_del_len  = len;
      end
      if (code inside {OP_M, OP_D, OP_N, OP_EQ, OP_X}) begin
        len_sum = {1'b0, read_ref_len} + {4'b0, len};
        read_ref_len = (len_sum > {1'b0, MAX31}) ? MAX31 : len_sum[30:0];
      end
    end
    if (last_op) begin
      pos_sum = {1'b0, begin_pos} + {1'b0, read_ref_len};
      if (pos_sum == '0) begin
        end_v = '1;
      end else if (pos_sum - 32'd1 > {1'b0, MAX31}) begin
        end_v = {1'b0, MAX31};
      end else begin
        end_v = pos_sum - 32'd1;
      end
      rev    = flag_word[FLAG_REVERSE];
      std_ok = !flag_word[FLAG_MATE_UNMAPPED] && !flag_word[FLAG_DUPLICATE] &&
               flag_word[FLAG_PAIRED] && !flag_word[FLAG_SECONDARY] &&
               !flag_word[FLAG_SUPPLEMENTARY];
      summary.end_pos      = end_v;
      summary.ref_length   = read_ref_len;
      summary.left_clip    = read_left_clip;
      summary.right_clip   = tail_clip;
      summary.has_deletion = read_del_seen;
      summary.deletion_len = read_del_len;
      if (flag_word[FLAG_READ1] && !flag_word[FLAG_READ2]) begin
        summary.mate_role = ROLE_READ1;
      end else if (flag_word[FLAG_READ2] && !flag_word[FLAG_READ1]) begin
        summary.mate_role = ROLE_READ2;
      end else begin
        summary.mate_role = ROLE_NONE;
      end
      summary.five_prime_pos  = rev ? end_v : {1'b0, begin_pos};
      summary.three_prime_pos = rev ? {1'b0, begin_pos} : end_v;
      summary.passes_standard = std_ok;
      summary.passes_insert   = std_ok && !flag_word[FLAG_QC_FAIL] && read_left_clip == '0 &&
                                tail_clip == '0 && !read_del_seen &&
                                map_quality >= insert_mapq_min;
      summary.clipped_at_min  = (read_left_clip >= clip_len_min) || (tail_clip >= clip_len_min);
      expected_reads.push_back(summary);
      clear_read();
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_reads.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual end_pos %0h",
               $time, end_pos);
      fail_count++;
    end else begin
      want = expected_reads.pop_front();
      result_count++;
      if (want.passes_insert) insert_count++;
      match_field("end_pos", want.end_pos, end_pos);
      match_field("ref_length", 32'(want.ref_length), 32'(ref_length));
      match_field("left_clip", 32'(want.left_clip), 32'(left_clip));
      match_field("right_clip", 32'(want.right_clip), 32'(right_clip));
      match_field("has_deletion", 32'(want.has_deletion), 32'(has_deletion));
      match_field("deletion_len", 32'(want.deletion_len), 32'(deletion_len));
      match_field("mate_role", 32'(want.mate_role), 32'(mate_role));
      match_field("five_prime_pos", want.five_prime_pos, five_prime_pos);
      match_field("three_prime_pos", want.three_prime_pos, three_prime_pos);
      match_field("passes_insert", 32'(want.passes_insert), 32'(passes_insert));
      match_field("passes_standard", 32'(want.passes_standard), 32'(passes_standard));
      match_field("clipped_at_min", 32'(want.clipped_at_min), 32'(clipped_at_min));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_read();
      insert_mapq_min = MIN_INSERT_MAPQ_RST;
      clip_len_min    = MIN_CLIP_LEN_RST;
      expected_reads.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_INSERT_MAPQ) begin
          insert_mapq_min = cfg_data[7:0];
        end else if (cfg_index == REG_MIN_CLIP_LEN) begin
          clip_len_min = cfg_data[27:0];
        end
      end
      if (in_valid && in_ready) decode_beat();
    end
    pending = expected_reads.size();
  end

endmodule

/* dv/alignment_record_cigar_flag_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alignment_record_cigar_flag_decoder_tb
// Streams CIGAR op beats of directed and random reads into the decoder under
// six register settings and three backpressure profiles, including a long
// output hold-off. The checker beside the block predicts every read result.
// ----------------------------------------------------------------------------
module alignment_record_cigar_flag_decoder_tb import arcfd_pkg::*; ();

  localparam int          LIMIT_NS     = 5_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          SEG_BEATS    = 140;
  localparam logic [27:0] MAX_OP_LEN   = 28'hFFF_FFFF;

  localparam logic [3:0] OP_I      = 4'd1;
  localparam logic [3:0] OP_P      = 4'd6;
  localparam logic [3:0] OP_SPARE9 = 4'd9;
  localparam logic [3:0] OP_SPARE  = 4'd15;

  localparam logic [15:0] FL_PAIRED = 16'h1 << FLAG_PAIRED;
  localparam logic [15:0] FL_MUNMAP = 16'h1 << FLAG_MATE_UNMAPPED;
  localparam logic [15:0] FL_REV    = 16'h1 << FLAG_REVERSE;
  localparam logic [15:0] FL_READ1  = 16'h1 << FLAG_READ1;
  localparam logic [15:0] FL_READ2  = 16'h1 << FLAG_READ2;
  localparam logic [15:0] FL_SEC    = 16'h1 << FLAG_SECONDARY;
  localparam logic [15:0] FL_QCFAIL = 16'h1 << FLAG_QC_FAIL;
  localparam logic [15:0] FL_DUP    = 16'h1 << FLAG_DUPLICATE;
  localparam logic [15:0] FL_SUPPL  = 16'h1 << FLAG_SUPPLEMENTARY;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           cigar_word;
  logic                  has_op;
  logic                  first_op;
  logic                  last_op;
  logic [30:0]           begin_pos;
  logic [15:0]           flag_word;
  logic [7:0]            map_quality;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [31:0]    end_pos;
  logic [30:0]           ref_length;
  logic [27:0]           left_clip;
  logic [27:0]           right_clip;
  logic                  has_deletion;
  logic [27:0]           deletion_len;
  logic [1:0]            mate_role;
  logic signed [31:0]    five_prime_pos;
  logic signed [31:0]    three_prime_pos;
  logic                  passes_insert;
  logic                  passes_standard;
  logic                  clipped_at_min;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int result_count;
  int insert_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int beats_sent    = 0;

  alignment_record_cigar_flag_decoder u_top (.*);

  alignment_record_cigar_flag_decoder_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_op(input logic [31:0] w, input logic h, input logic f, input logic l,
                         input logic [30:0] bp, input logic [15:0] fl, input logic [7:0] mq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cigar_word  <= w;
    has_op      <= h;
    first_op    <= f;
    last_op     <= l;
    begin_pos   <= bp;
    flag_word   <= fl;
    map_quality <= mq;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_read();
    int          kind;
    int          nops;
    int          pick;
    bit          clean;
    bit          skip_first;
    logic [3:0]  code;
    logic [27:0] len;
    logic [30:0] bp;
    logic [15:0] fl;
    logic [7:0]  mq;
    kind       = $urandom_range(99);
    clean      = ($urandom_range(3) == 0);
    skip_first = ($urandom_range(19) == 0);
    pick = $urandom_range(99);
    if (pick < 80) bp = 31'($urandom);
    else if (pick < 90) bp = 31'($urandom_range(20));
    else bp = MAX31 - 31'($urandom_range(1000));
    if (clean || $urandom_range(1) == 1) begin
      fl = (16'($urandom) & ~(FL_MUNMAP | FL_DUP | FL_SEC | FL_SUPPL)) | FL_PAIRED;
      if ($urandom_range(9) != 0) fl = fl & ~FL_QCFAIL;
    end else begin
      fl = 16'($urandom);
    end
    mq = 8'($urandom);
    if (kind < 8) begin
      send_op($urandom, 1'b0, 1'($urandom), 1'b1, bp, fl, mq);
    end else if (kind < 16) begin
      send_op($urandom, 1'($urandom), 1'($urandom), 1'($urandom), 31'($urandom),
              16'($urandom), 8'($urandom));
    end else begin
      nops = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
      for (int i = 0; i < nops; i++) begin
        if (clean) begin
          case ($urandom_range(4))
            0: code = OP_M;
            1: code = OP_I;
            2: code = OP_N;
            3: code = OP_EQ;
            default: code = OP_X;
          endcase
        end else if ((i == 0 || i == nops - 1) && $urandom_range(1) == 1) begin
          code = ($urandom_range(1) == 1) ? OP_S : OP_H;
        end else if ($urandom_range(5) == 0) begin
          code = 4'($urandom_range(15));
        end else begin
          code = 4'($urandom_range(8));
        end
        pick = $urandom_range(99);
        if (pick < 85) len = 28'($urandom_range(300));
        else if (pick < 93) len = 28'($urandom);
        else len = MAX_OP_LEN - 28'($urandom_range(3));
        if (i > 0 && $urandom_range(24) == 0) begin
          send_op($urandom, 1'b0, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
        end
        if (i == nops - 1) begin
          send_op({len, code}, 1'b1, (i == 0) && !skip_first, 1'b1, bp, fl, mq);
        end else begin
          send_op({len, code}, 1'b1, (i == 0) && !skip_first, 1'b0, 31'($urandom),
                  16'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int target;
    rst         = 1'b1;
    in_valid    = 1'b0;
    cigar_word  = '0;
    has_op      = 1'b0;
    first_op    = 1'b0;
    last_op     = 1'b0;
    begin_pos   = '0;
    flag_word   = '0;
    map_quality = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 87;

    // empty reads at both ends of the position range, then a plain match read
    send_op('0, 1'b0, 1'b1, 1'b1, '0, FL_PAIRED | FL_READ1, 8'd60);
    send_op($urandom, 1'b0, 1'b0, 1'b1, MAX31, 16'hFFFF, 8'hFF);
    send_op({28'd100, OP_M}, 1'b1, 1'b1, 1'b1, 31'd1000, FL_PAIRED | FL_READ2, 8'd40);
    // every defined op code and two spare codes in one read, clipped at both ends
    send_op({28'd5, OP_S}, 1'b1, 1'b1, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd50, OP_M}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd4, OP_I}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd3, OP_D}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd200, OP_N}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd2, OP_P}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd10, OP_EQ}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd1, OP_X}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd7, OP_SPARE9}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom),
            8'($urandom));
    send_op({28'd3, OP_SPARE}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom),
            8'($urandom));
    send_op({28'd7, OP_H}, 1'b1, 1'b0, 1'b1, 31'd12345,
            FL_PAIRED | FL_REV | FL_READ1 | FL_READ2, 8'd39);
    // end position reaches the top of the range
    send_op({28'd1, OP_M}, 1'b1, 1'b1, 1'b1, MAX31, FL_PAIRED | FL_QCFAIL | FL_DUP, 8'd200);
    // reference length saturates
    for (int i = 0; i < 9; i++) begin
      send_op({MAX_OP_LEN, OP_M}, 1'b1, i == 0, i == 8, 31'd5,
              FL_SEC | FL_SUPPL | FL_MUNMAP | FL_REV, 8'd0);
    end
    // read without a first mark
    send_op({28'd12, OP_D}, 1'b1, 1'b0, 1'b0, 31'($urandom), 16'($urandom), 8'($urandom));
    send_op({28'd9, OP_S}, 1'b1, 1'b0, 1'b1, 31'd77, FL_PAIRED | FL_READ2, 8'd90);

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      case (seg / 2)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          write_reg(REG_MIN_INSERT_MAPQ, '0);
          write_reg(REG_MIN_CLIP_LEN, '0);
        end
        1: begin
          write_reg(REG_MIN_INSERT_MAPQ, '1);
          write_reg(REG_MIN_CLIP_LEN, {4'hF, MAX_OP_LEN});
        end
        2: begin
          write_reg(REG_MIN_INSERT_MAPQ, $urandom);
          write_reg(REG_MIN_CLIP_LEN, 32'($urandom_range(400)));
        end
        3: begin
          write_reg(CFG_IDX_W'($urandom_range(REG_MIN_CLIP_LEN + 1, (1 << CFG_IDX_W) - 1)),
                    $urandom);
          write_reg(REG_MIN_INSERT_MAPQ, 32'(MIN_INSERT_MAPQ_RST));
          write_reg(REG_MIN_CLIP_LEN, 32'(MIN_CLIP_LEN_RST));
        end
        4: begin
          write_reg(REG_MIN_INSERT_MAPQ, $urandom);
          write_reg(REG_MIN_CLIP_LEN, $urandom);
        end
        default: begin
          write_reg(REG_MIN_INSERT_MAPQ, $urandom);
          write_reg(REG_MIN_CLIP_LEN, 32'($urandom_range(40)));
        end
      endcase
      // hold the output long enough to back up the op queue
      if (seg == 0 || seg == 4) hold_left = 100;
      target = beats_sent + SEG_BEATS;
      while (beats_sent < target) send_random_read();
    end
    drain();

    $display("Summary: %0d op beats over six register settings and three stall profiles,",
             beats_sent);
    $display("  %0d read results checked, %0d of them passing the insert filter",
             result_count, insert_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
